### rtl/core/mlfl_pkg.sv
package mlfl_pkg;

    localparam int NUM_TARGETS  = 4;
    localparam int CHANNELS_DEF = 4;
    localparam int LEVEL_W      = 8;
    localparam int STEPS_W      = 16;
    localparam int NUM_W        = STEPS_W + 1;
    localparam int DIGITS       = 8;
    localparam int PROD_W       = NUM_W + DIGITS;
    localparam int REM_W        = PROD_W - DIGITS;
    localparam int LIMIT_FULL   = 255;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [LEVEL_W-1:0] target_0;
        logic [LEVEL_W-1:0] target_1;
        logic [LEVEL_W-1:0] target_2;
        logic [LEVEL_W-1:0] target_3;
        logic [STEPS_W-1:0] fade_steps;
        logic [LEVEL_W-1:0] trim_sample;
    } item_t;

    typedef struct packed {
        logic [1:0]         channel;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] duty;
        logic               any_on;
        logic               last_of_run;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_MUL,
        ST_ADJ,
        ST_DIV,
        ST_WB,
        ST_EMIT
    } mlfl_state_t;

endpackage

### rtl/core/multichannel_linear_fade_with_limiter.sv
// Each step works channel by channel over min(CHANNELS, 4) channels: first the new level of
// every channel, then its duty, each by a multiply, an adjust and a divide step on the shared
// bit-serial multiply/divide unit. A step that does not run goes back to idle from the check
// state. No new item is taken until the last result of the step has been issued.
// Reset (rst_n, async, active low) clears all levels, position and step count: idle.
module multichannel_linear_fade_with_limiter #(
    parameter int CHANNELS = mlfl_pkg::CHANNELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mlfl_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mlfl_pkg::result_t result
);
    import mlfl_pkg::*;

    localparam int ACTIVE = (CHANNELS < NUM_TARGETS) ? CHANNELS : NUM_TARGETS;
    localparam int CH_W   = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam logic [CH_W-1:0]  LAST_CH    = CH_W'(ACTIVE - 1);
    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(DIGITS - 1);

    mlfl_state_t        state_reg, state_next;
    logic [LEVEL_W-1:0] from_reg [ACTIVE];
    logic [LEVEL_W-1:0] from_next [ACTIVE];
    logic [LEVEL_W-1:0] to_reg [ACTIVE];
    logic [LEVEL_W-1:0] to_next [ACTIVE];
    logic [LEVEL_W-1:0] cur_reg [ACTIVE];
    logic [LEVEL_W-1:0] cur_next [ACTIVE];
    logic [STEPS_W-1:0] pos_reg, pos_next;
    logic [STEPS_W-1:0] total_reg, total_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               duty_pass_reg, duty_pass_next;
    logic               result_valid_reg, result_valid_next;

    logic               neg_reg, neg_next;
    logic [LEVEL_W-1:0] trim_reg, trim_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [NUM_W-1:0]   mcand_reg, mcand_next;
    logic [DIGITS-1:0]  mplier_reg, mplier_next;
    result_t            result_reg, result_next;

    logic [LEVEL_W-1:0] tgt [NUM_TARGETS];
    logic [LEVEL_W-1:0] sel_from, sel_to, sel_cur;
    logic [STEPS_W-1:0] den;
    logic [PROD_W-1:0]  mul_sum, adj_sum, div_acc;
    logic [REM_W:0]     div_shift, div_trial;
    logic               q_bit;
    logic [DIGITS-1:0]  quot;
    logic               any_on;
    logic               last_ch;

    assign tgt[0] = item.target_0;
    assign tgt[1] = item.target_1;
    assign tgt[2] = item.target_2;
    assign tgt[3] = item.target_3;

    assign sel_from = from_reg[ch_reg];
    assign sel_to   = to_reg[ch_reg];
    assign sel_cur  = cur_reg[ch_reg];
    assign last_ch  = (ch_reg == LAST_CH);
    assign den      = duty_pass_reg ? STEPS_W'(LIMIT_FULL) : total_reg;
    assign quot     = acc_reg[DIGITS-1:0];

    // shift-add, multiplier MSB first
    assign mul_sum = {acc_reg[PROD_W-2:0], 1'b0}
                   + (mplier_reg[DIGITS-1] ? PROD_W'(mcand_reg) : PROD_W'(0));
    // floor of a falling fade: bias by den - 1 before dividing
    assign adj_sum = acc_reg + (neg_reg ? PROD_W'(den - STEPS_W'(1)) : PROD_W'(0));

    // restoring division, quotient below 256 so the high part starts below den
    assign div_shift = {acc_reg[PROD_W-1:DIGITS], acc_reg[DIGITS-1]};
    assign div_trial = div_shift - (REM_W + 1)'(den);
    assign q_bit     = ~div_trial[REM_W];
    assign div_acc   = {(q_bit ? div_trial[REM_W-1:0] : div_shift[REM_W-1:0]),
                        acc_reg[DIGITS-2:0], q_bit};

    always_comb
    begin
        any_on = 1'b0;
        for (int i = 0; i < ACTIVE; i++)
        begin
            any_on = any_on | (cur_reg[i] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pos_reg          <= '0;
            total_reg        <= '0;
            ch_reg           <= '0;
            cnt_reg          <= '0;
            duty_pass_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < ACTIVE; i++)
            begin
                from_reg[i] <= '0;
                to_reg[i]   <= '0;
                cur_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            pos_reg          <= pos_next;
            total_reg        <= total_next;
            ch_reg           <= ch_next;
            cnt_reg          <= cnt_next;
            duty_pass_reg    <= duty_pass_next;
            result_valid_reg <= result_valid_next;
            from_reg         <= from_next;
            to_reg           <= to_next;
            cur_reg          <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        trim_reg   <= trim_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        from_next         = from_reg;
        to_next           = to_reg;
        cur_next          = cur_reg;
        pos_next          = pos_reg;
        total_next        = total_reg;
        ch_next           = ch_reg;
        cnt_next          = cnt_reg;
        duty_pass_next    = duty_pass_reg;
        neg_next          = neg_reg;
        trim_next         = trim_reg;
        acc_next          = acc_reg;
        mcand_next        = mcand_reg;
        mplier_next       = mplier_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg & result_stall;
        item_stall        = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    trim_next  = item.trim_sample;
                    state_next = ST_CHECK;
                    if (item.action == ACT_START)
                    begin
                        for (int i = 0; i < ACTIVE; i++)
                        begin
                            from_next[i] = cur_reg[i];
                            to_next[i]   = tgt[i];
                        end
                        pos_next   = '0;
                        total_next = item.fade_steps;
                    end
                end
            end
            ST_CHECK:
            begin
                ch_next        = '0;
                duty_pass_next = 1'b0;
                state_next     = (pos_reg == total_reg) ? ST_IDLE : ST_LOAD;
            end
            ST_LOAD:
            begin
                acc_next = '0;
                cnt_next = '0;
                if (duty_pass_reg)
                begin
                    mcand_next  = NUM_W'(sel_cur - LEVEL_W'(1));
                    mplier_next = trim_reg;
                    neg_next    = 1'b0;
                end
                else
                begin
                    mcand_next  = NUM_W'(pos_reg) + NUM_W'(1);
                    neg_next    = (sel_to < sel_from);
                    mplier_next = (sel_to < sel_from) ? (sel_from - sel_to)
                                                      : (sel_to - sel_from);
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next    = mul_sum;
                mplier_next = {mplier_reg[DIGITS-2:0], 1'b0};
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_DIGIT)
                begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                acc_next   = adj_sum;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                acc_next = div_acc;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_DIGIT)
                begin
                    state_next = duty_pass_reg ? ST_EMIT : ST_WB;
                end
            end
            ST_WB:
            begin
                cur_next[ch_reg] = neg_reg ? (sel_from - quot) : (sel_from + quot);
                state_next       = ST_LOAD;
                if (last_ch)
                begin
                    pos_next       = pos_reg + STEPS_W'(1);
                    ch_next        = '0;
                    duty_pass_next = 1'b1;
                end
                else
                begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next       = 1'b1;
                    result_next.channel     = 2'(ch_reg);
                    result_next.level       = sel_cur;
                    result_next.duty        = (sel_cur == '0) ? '0 : (quot + LEVEL_W'(1));
                    result_next.any_on      = any_on;
                    result_next.last_of_run = last_ch;
                    if (last_ch)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/core/mlfl_chk.sv
module mlfl_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input mlfl_pkg::result_t result
);
    import mlfl_pkg::*;

    // held result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // block is busy in the cycle after taking an item
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item taken on consecutive cycles");

    // mid-run results keep the input side closed
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_of_run |-> item_stall)
        else $error("item accepted while a step is still emitting");

    // limiter never raises the level and keeps zero exactly at zero
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.duty <= result.level)
                         && ((result.level == '0) == (result.duty == '0)))
        else $error("duty out of range for level");

    a_any_on: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.level != '0) |-> result.any_on)
        else $error("any_on low with a lit channel");

endmodule

bind multichannel_linear_fade_with_limiter mlfl_chk u_mlfl_chk (.*);

### verif/multichannel_linear_fade_with_limiter_test.sv
`timescale 1ns / 100ps

module multichannel_linear_fade_with_limiter_test;

    import mlfl_pkg::*;

    localparam int NCH = (CHANNELS_DEF < NUM_TARGETS) ? CHANNELS_DEF : NUM_TARGETS;
    localparam int RUN_ITEMS = 320;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 400;

    typedef struct packed {
        item_t              stim;
        logic               typed;
        logic [2:0]         n;
        logic [0:3][7:0]    lvl;
        logic [0:3][7:0]    dty;
        logic               on;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    item_t      item;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result;

    logic [7:0]  from_lv [4];
    logic [7:0]  to_lv [4];
    logic [7:0]  cur_lv [4];
    logic [15:0] fade_pos;
    logic [15:0] fade_len;

    result_t step_res [$];
    result_t pending [$];
    row_t    plan [$];

    int fail_count = 0;
    int sent = 0;
    int steps_ran = 0;
    int fades = 0;
    int checked = 0;
    int drains = 0;
    int cycles = 0;
    int rx_hold = 0;
    bit rx_calm = 0;
    bit tx_calm = 0;

    multichannel_linear_fade_with_limiter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [7:0] ramp(input logic [7:0] a, input logic [7:0] b,
                                        input longint unsigned num,
                                        input longint unsigned den);
        longint unsigned span;
        if (b >= a)
        begin
            span = (64'(b - a) * num) / den;
            return a + span[7:0];
        end
        // falling: round the quotient away from zero so the level floors
        span = (64'(a - b) * num + den - 1) / den;
        return a - span[7:0];
    endfunction

    function automatic logic [7:0] limit_duty(input logic [7:0] lv, input logic [7:0] trim);
        int unsigned p;
        if (lv == 8'd0)
            return 8'd0;
        p = ((32'(lv) - 1) * 32'(trim)) / LIMIT_FULL;
        return 8'(1 + p);
    endfunction

    function automatic void fade_step(input item_t x);
        logic [7:0]  tg [4];
        result_t     r;
        bit          on;
        longint unsigned num;
        tg = '{x.target_0, x.target_1, x.target_2, x.target_3};
        step_res.delete();
        if (x.action == ACT_START)
        begin
            for (int i = 0; i < NUM_TARGETS; i++)
            begin
                from_lv[i] = cur_lv[i];
                to_lv[i] = tg[i];
            end
            fade_pos = 16'd0;
            fade_len = x.fade_steps;
        end
        if (fade_pos == fade_len)
            return;
        num = 64'(fade_pos) + 1;
        for (int i = 0; i < NCH; i++)
            cur_lv[i] = ramp(from_lv[i], to_lv[i], num, 64'(fade_len));
        on = 0;
        for (int i = 0; i < NUM_TARGETS; i++)
            if (cur_lv[i] != 8'd0)
                on = 1;
        for (int i = 0; i < NCH; i++)
        begin
            r.channel = 2'(i);
            r.level = cur_lv[i];
            r.duty = limit_duty(cur_lv[i], x.trim_sample);
            r.any_on = on;
            r.last_of_run = (i == NCH - 1);
            step_res.push_back(r);
        end
        fade_pos = fade_pos + 16'd1;
    endfunction

    function automatic item_t mk(input logic act, input logic [7:0] t0, input logic [7:0] t1,
                                 input logic [7:0] t2, input logic [7:0] t3,
                                 input logic [15:0] steps, input logic [7:0] trim);
        item_t x;
        x.action = act;
        x.target_0 = t0;
        x.target_1 = t1;
        x.target_2 = t2;
        x.target_3 = t3;
        x.fade_steps = steps;
        x.trim_sample = trim;
        return x;
    endfunction

    function automatic row_t predicted(input item_t x);
        row_t r;
        r = '0;
        r.stim = x;
        return r;
    endfunction

    function automatic row_t exact(input item_t x, input logic [2:0] n,
                                   input logic [0:3][7:0] lvl, input logic [0:3][7:0] dty,
                                   input logic on);
        row_t r;
        r.stim = x;
        r.typed = 1'b1;
        r.n = n;
        r.lvl = lvl;
        r.dty = dty;
        r.on = on;
        return r;
    endfunction

    function automatic logic [7:0] pick_level();
        int c;
        c = $urandom_range(0, 9);
        if (c == 0)
            return 8'd0;
        if (c == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic item_t random_item(input logic act);
        return mk(act, pick_level(), pick_level(), pick_level(), pick_level(),
                  16'($urandom_range(0, 65535)), pick_level());
    endfunction

    function automatic void check_result(input result_t got);
        result_t want;
        if (pending.size() == 0)
        begin
            $error("unexpected result: channel %0d level %0d duty %0d",
                   got.channel, got.level, got.duty);
            fail_count++;
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.channel !== want.channel)
        begin
            $error("channel: expected %0d, got %0d", want.channel, got.channel);
            fail_count++;
        end
        if (got.level !== want.level)
        begin
            $error("level: expected %0d, got %0d", want.level, got.level);
            fail_count++;
        end
        if (got.duty !== want.duty)
        begin
            $error("duty: expected %0d, got %0d", want.duty, got.duty);
            fail_count++;
        end
        if (got.any_on !== want.any_on)
        begin
            $error("any_on: expected %0d, got %0d", want.any_on, got.any_on);
            fail_count++;
        end
        if (got.last_of_run !== want.last_of_run)
        begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
            fail_count++;
        end
    endfunction

    // result side: check, then hold stall for a drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            check_result(result);
            if (checked % 32 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            rx_hold = rx_calm ? 0 : $urandom_range(0, 6);
        end
        if (rx_hold > 0)
        begin
            result_stall <= 1'b1;
            rx_hold--;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send(input row_t r);
        int      gap;
        result_t e;
        if (sent % 24 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= r.stim;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent++;
        if (r.stim.action == ACT_START)
            fades++;
        fade_step(r.stim);
        if (step_res.size() != 0)
            steps_ran++;
        if (r.typed)
        begin
            for (int i = 0; i < r.n; i++)
            begin
                e.channel = 2'(i);
                e.level = r.lvl[i];
                e.duty = r.dty[i];
                e.any_on = r.on;
                e.last_of_run = (i == r.n - 1);
                pending.push_back(e);
            end
        end
        else
            foreach (step_res[i])
                pending.push_back(step_res[i]);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0)
            @(posedge clk);
        drains++;
    endtask

    initial
    begin
        int          pick;
        int          ticks;
        logic [15:0] steps;
        item_t       x;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        for (int i = 0; i < NUM_TARGETS; i++)
        begin
            from_lv[i] = 8'd0;
            to_lv[i] = 8'd0;
            cur_lv[i] = 8'd0;
        end
        fade_pos = 16'd0;
        fade_len = 16'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // idle after reset, zero step count, finished fade
        plan.push_back(exact(mk(ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd255),
                             3'd0, '0, '0, 1'b0));
        plan.push_back(exact(mk(ACT_START, 8'd255, 8'd255, 8'd255, 8'd255, 16'd0, 8'd255),
                             3'd0, '0, '0, 1'b0));
        plan.push_back(exact(mk(ACT_TICK, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 8'd0),
                             3'd0, '0, '0, 1'b0));
        plan.push_back(exact(mk(ACT_START, 8'd255, 8'd255, 8'd255, 8'd255, 16'd1, 8'd255),
                             3'(NCH), {4{8'd255}}, {4{8'd255}}, 1'b1));
        plan.push_back(exact(mk(ACT_TICK, 8'hAA, 8'h55, 8'hAA, 8'h55, 16'h5555, 8'd255),
                             3'd0, '0, '0, 1'b0));
        plan.push_back(exact(mk(ACT_START, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 8'd0),
                             3'(NCH), '0, '0, 1'b0));
        plan.push_back(exact(mk(ACT_START, 8'd255, 8'd128, 8'd1, 8'd0, 16'd1, 8'd0),
                             3'(NCH), {8'd255, 8'd128, 8'd1, 8'd0}, {8'd1, 8'd1, 8'd1, 8'd0},
                             1'b1));
        plan.push_back(predicted(mk(ACT_START, 8'd0, 8'd255, 8'd0, 8'd255, 16'd3, 8'd128)));
        plan.push_back(predicted(mk(ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd1)));
        plan.push_back(predicted(mk(ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd254)));
        plan.push_back(exact(mk(ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd200),
                             3'd0, '0, '0, 1'b0));
        plan.push_back(predicted(mk(ACT_START, 8'd170, 8'd85, 8'd0, 8'd255, 16'hFFFF, 8'd255)));
        plan.push_back(predicted(mk(ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd255)));
        plan.push_back(predicted(mk(ACT_START, 8'd13, 8'd200, 8'd99, 8'd7, 16'd5, 8'd200)));
        plan.push_back(predicted(mk(ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd100)));
        plan.push_back(predicted(mk(ACT_START, 8'd255, 8'd0, 8'd255, 8'd0, 16'd2, 8'd64)));
        plan.push_back(predicted(mk(ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd64)));
        plan.push_back(exact(mk(ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd64),
                             3'd0, '0, '0, 1'b0));
        plan.push_back(predicted(mk(ACT_START, 8'd0, 8'd1, 8'd254, 8'd255, 16'h8000, 8'd127)));
        plan.push_back(predicted(mk(ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd128)));

        foreach (plan[i])
            send(plan[i]);
        drain();

        while (sent < RUN_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                send(predicted(random_item(ACT_TICK)));
            pick = $urandom_range(0, 99);
            if (pick < 8)
                steps = 16'd0;
            else if (pick < 75)
                steps = 16'($urandom_range(1, 6));
            else if (pick < 90)
                steps = 16'($urandom_range(7, 40));
            else
                steps = 16'($urandom_range(0, 65535));
            x = random_item(ACT_START);
            x.fade_steps = steps;
            send(predicted(x));
            if (steps >= 16'd1 && steps <= 16'd6)
                ticks = $urandom_range(steps - 1, steps + 1);
            else
                ticks = $urandom_range(0, 6);
            repeat (ticks)
                send(predicted(random_item(ACT_TICK)));
            if ($urandom_range(0, 29) == 0)
                drain();
        end

        item_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d transactions sent, %0d fades started, %0d steps ran, %0d results checked",
                 sent, fades, steps_ran, checked);
        $display("random stalls on both sides, %0d full drains, %0d cycles", drains, cycles);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/mlfl_pkg.sv
rtl/core/multichannel_linear_fade_with_limiter.sv
rtl/core/mlfl_chk.sv
verif/multichannel_linear_fade_with_limiter_test.sv
